### sv/fbar_pkg.sv
// ----------------------------------------------------------------------------
// fbar_pkg: shared types and constants of the alpha blend rectangle fill core
// Holds the field widths of the command and pixel words, the command kind
// codes and the fixed-point constants of the divide by full scale.
// ----------------------------------------------------------------------------
package fbar_pkg;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 8;
    localparam int SIZE_W  = 9;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 4 * CHAN_W;
    localparam int SUM_W   = 2 * CHAN_W;

    // Coordinates and clipped bounds are kept wide enough for the largest
    // supported frame edge (4096) and for pos + size (at most 766).
    localparam int COORD_W = 13;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    // x / 255 == (x * 32897) >> 23 for every 16-bit x.
    localparam int               RECIP_SHIFT = 23;
    localparam logic [SUM_W-1:0] RECIP_255   = 16'd32897;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

endpackage

### sv/fbar_if.sv
// ----------------------------------------------------------------------------
// fbar_if: command and pixel channels of the alpha blend rectangle fill core
// Each channel carries valid, ready and its payload; a word moves at a
// rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface fbar_cmd_if import fbar_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0] rect_width;
    logic [SIZE_W-1:0] rect_height;
    logic [CHAN_W-1:0] src_red;
    logic [CHAN_W-1:0] src_green;
    logic [CHAN_W-1:0] src_blue;
    logic [CHAN_W-1:0] src_alpha;

    modport source (
        output valid, kind, pos_x, pos_y, rect_width, rect_height,
               src_red, src_green, src_blue, src_alpha,
        input  ready
    );
    modport sink (
        input  valid, kind, pos_x, pos_y, rect_width, rect_height,
               src_red, src_green, src_blue, src_alpha,
        output ready
    );
endinterface

interface fbar_pix_if import fbar_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] pix_red;
    logic [CHAN_W-1:0] pix_green;
    logic [CHAN_W-1:0] pix_blue;
    logic [CHAN_W-1:0] pix_alpha;

    modport source (
        output valid, pix_red, pix_green, pix_blue, pix_alpha,
        input  ready
    );
    modport sink (
        input  valid, pix_red, pix_green, pix_blue, pix_alpha,
        output ready
    );
endinterface

### sv/framebuffer_alpha_rect_fill_core.sv
// ----------------------------------------------------------------------------
// framebuffer_alpha_rect_fill_core: 2D clear, alpha blend fill and pixel read
// A frame of FB_WIDTH x FB_HEIGHT RGBA8 pixels lives in one synchronous
// memory; fills run a read-modify-write pipeline over the clipped rectangle.
// ----------------------------------------------------------------------------
// One command is in work at a time; the single write port moves one pixel per
// cycle, which sets the clear and fill time; a new command is taken while a result waits.
// Reset (synchronous, active low) first zeroes all FB_WIDTH*FB_HEIGHT pixels in a sweep.
module framebuffer_alpha_rect_fill_core import fbar_pkg::*; #(
    parameter int FB_WIDTH  = 256,
    parameter int FB_HEIGHT = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fbar_cmd_if.sink      i_cmd,
    fbar_pix_if.source    o_pix
);

    localparam int NPIX = FB_WIDTH * FB_HEIGHT;
    localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;

    localparam logic [COORD_W-1:0] FBW_C    = COORD_W'(FB_WIDTH);
    localparam logic [COORD_W-1:0] FBH_C    = COORD_W'(FB_HEIGHT);
    localparam logic [AW-1:0]      FBW_A    = AW'(FB_WIDTH);
    localparam logic [AW-1:0]      LAST_PIX = AW'(NPIX - 1);

    // Controller states, one-hot.
    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,  // zeroing sweep after reset
        ST_IDLE   = 9'b000000010,  // waiting for a command word
        ST_SETUP  = 9'b000000100,  // clip bounds, start address, products
        ST_CLEAR  = 9'b000001000,  // write the clear color to every pixel
        ST_FILL   = 9'b000010000,  // issue one pixel read per cycle
        ST_DRAIN  = 9'b000100000,  // let the blend pipeline write back
        ST_READ   = 9'b001000000,  // issue the single pixel read
        ST_RDWAIT = 9'b010000000,  // capture the read data
        ST_DONE   = 9'b100000000   // hand the result to the output register
    } t_state;

    t_state r_state, n_state;

    // Command latched at accept.
    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_px;
    logic [POS_W-1:0]  r_py;
    logic [SIZE_W-1:0] r_w;
    logic [SIZE_W-1:0] r_h;
    logic [PIX_W-1:0]  r_cmd_word;   // {alpha, blue, green, red}

    // Walk of the clipped rectangle.
    logic [COORD_W-1:0] r_x, r_y, r_x_last, r_y_last;
    logic [AW-1:0]      r_row_start;
    logic [AW-1:0]      r_addr;

    // Per-command blend operands.
    logic [CHAN_W-1:0] r_inv_a;
    logic [SUM_W-1:0]  r_src_prod [3];

    // Blend pipeline: stage 1 sees the read data, stage 2 writes back.
    logic              r_p1_vld, r_p2_vld;
    logic [AW-1:0]     r_p1_addr, r_p2_addr;
    logic [CHAN_W-1:0] r_p2_alpha;
    logic [SUM_W-1:0]  r_sum [3];

    // Frame memory.
    logic [PIX_W-1:0] r_mem [NPIX];
    logic [PIX_W-1:0] r_rd_data;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [PIX_W-1:0] mem_wdata;

    // Result and output register.
    logic [PIX_W-1:0] r_res;
    logic [PIX_W-1:0] r_out_word;
    logic             r_out_valid;

    // Setup arithmetic, from the latched command.
    logic [COORD_W-1:0] c_px, c_py, sum_x, sum_y, x_end, y_end;
    logic               fill_empty, rd_inside;
    logic [AW-1:0]      row_start;

    logic               accept, out_load, sweep, row_last, rect_last;
    logic [CHAN_W-1:0]  blend_q [3];
    logic [2*SUM_W-1:0] recip_prod [3];

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_pix.ready);
    assign sweep    = (r_state == ST_INIT) || (r_state == ST_CLEAR);

    assign c_px  = COORD_W'(r_px);
    assign c_py  = COORD_W'(r_py);
    assign sum_x = c_px + COORD_W'(r_w);
    assign sum_y = c_py + COORD_W'(r_h);
    assign x_end = (sum_x > FBW_C) ? FBW_C : sum_x;
    assign y_end = (sum_y > FBH_C) ? FBH_C : sum_y;

    // The rectangle is empty when its corner lies outside the frame or a
    // side has zero length; otherwise x_end and y_end exceed the corner.
    assign rd_inside  = (c_px < FBW_C) && (c_py < FBH_C);
    assign fill_empty = !rd_inside || (r_w == '0) || (r_h == '0);
    assign row_start  = AW'(r_py) * FBW_A + AW'(r_px);

    assign row_last  = (r_x == r_x_last);
    assign rect_last = row_last && (r_y == r_y_last);

    // ------------------------------------------------------------------
    // Controller.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_addr == LAST_PIX) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                case (r_kind)
                    KIND_CLEAR: n_state = ST_CLEAR;
                    KIND_FILL:  n_state = fill_empty ? ST_DONE : ST_FILL;
                    KIND_READ:  n_state = rd_inside ? ST_READ : ST_DONE;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_CLEAR: begin
                if (r_addr == LAST_PIX) n_state = ST_DONE;
            end
            ST_FILL: begin
                if (rect_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                // The last write happens in the cycle stage 2 is valid, so
                // the memory is settled once both stages are empty.
                if (!r_p1_vld && !r_p2_vld) n_state = ST_DONE;
            end
            ST_READ:   n_state = ST_RDWAIT;
            ST_RDWAIT: n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default:   n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_addr      <= '0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= (r_state == ST_FILL);
            r_p2_vld <= r_p1_vld;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_SETUP: begin
                    r_addr <= (r_kind == KIND_CLEAR) ? '0 : row_start;
                end
                ST_INIT, ST_CLEAR: begin
                    if (r_addr != LAST_PIX) r_addr <= r_addr + 1'b1;
                end
                ST_FILL: begin
                    if (row_last) begin
                        r_addr <= r_row_start + FBW_A;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Command latch, rectangle walk and per-command operands.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= i_cmd.kind;
            r_px       <= i_cmd.pos_x;
            r_py       <= i_cmd.pos_y;
            r_w        <= i_cmd.rect_width;
            r_h        <= i_cmd.rect_height;
            r_cmd_word <= {i_cmd.src_alpha, i_cmd.src_blue, i_cmd.src_green,
                           i_cmd.src_red};
        end

        case (r_state)
            ST_SETUP: begin
                r_x           <= c_px;
                r_y           <= c_py;
                r_x_last      <= x_end - 1'b1;
                r_y_last      <= y_end - 1'b1;
                r_row_start   <= row_start;
                r_res         <= '0;
                r_inv_a       <= FULL_SCALE - r_cmd_word[3*CHAN_W +: CHAN_W];
                for (int c = 0; c < 3; c++) begin
                    r_src_prod[c] <= SUM_W'(r_cmd_word[c*CHAN_W +: CHAN_W])
                                   * SUM_W'(r_cmd_word[3*CHAN_W +: CHAN_W]);
                end
            end
            ST_FILL: begin
                if (row_last) begin
                    r_x         <= c_px;
                    r_y         <= r_y + 1'b1;
                    r_row_start <= r_row_start + FBW_A;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            ST_RDWAIT: begin
                r_res <= r_rd_data;
            end
            default: ;
        endcase

        if (out_load) r_out_word <= r_res;
    end

    // ------------------------------------------------------------------
    // Blend pipeline. Stage 1 forms dst*(255-a) + src*a per channel from
    // the read word; stage 2 divides by 255 with a reciprocal multiply
    // and writes the pixel back with its alpha byte untouched. Every
    // pixel of a fill is visited once, so reads never meet a pending
    // write within a command, and DRAIN empties the pipe before the next.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_p1_addr  <= r_addr;
        r_p2_addr  <= r_p1_addr;
        r_p2_alpha <= r_rd_data[3*CHAN_W +: CHAN_W];
        for (int c = 0; c < 3; c++) begin
            r_sum[c] <= SUM_W'(r_rd_data[c*CHAN_W +: CHAN_W]) * SUM_W'(r_inv_a)
                      + r_src_prod[c];
        end
    end

    // The quotient never exceeds 255, so only the channel bits are kept.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            recip_prod[c] = (2*SUM_W)'(r_sum[c]) * (2*SUM_W)'(RECIP_255);
            blend_q[c]    = recip_prod[c][RECIP_SHIFT +: CHAN_W];
        end
    end

    // ------------------------------------------------------------------
    // Frame memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    assign mem_raddr = r_addr;
    assign mem_we    = sweep || r_p2_vld;
    assign mem_waddr = sweep ? r_addr : r_p2_addr;
    assign mem_wdata = (r_state == ST_INIT) ? '0 :
                       (r_state == ST_CLEAR) ? r_cmd_word :
                       {r_p2_alpha, blend_q[2], blend_q[1], blend_q[0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rd_data <= r_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Ports.
    // ------------------------------------------------------------------
    assign i_cmd.ready     = (r_state == ST_IDLE);
    assign o_pix.valid     = r_out_valid;
    assign o_pix.pix_red   = r_out_word[0*CHAN_W +: CHAN_W];
    assign o_pix.pix_green = r_out_word[1*CHAN_W +: CHAN_W];
    assign o_pix.pix_blue  = r_out_word[2*CHAN_W +: CHAN_W];
    assign o_pix.pix_alpha = r_out_word[3*CHAN_W +: CHAN_W];

endmodule

### sv/fbar_checker.sv
// ----------------------------------------------------------------------------
// fbar_checker: port-level assertions of the alpha blend rectangle fill core
// Tracks words accepted but not yet answered and checks reset and output
// behavior seen at the ports.
// ----------------------------------------------------------------------------
module fbar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_valid,
    input logic        i_cmd_ready,
    input logic        i_pix_valid,
    input logic        i_pix_ready,
    input logic [31:0] i_pix_word
);

    logic       cmd_acc, pix_acc;
    logic [1:0] r_pending;

    assign cmd_acc = i_cmd_valid && i_cmd_ready;
    assign pix_acc = i_pix_valid && i_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (cmd_acc && !pix_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (pix_acc && !cmd_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // Reset starts the zeroing sweep, so nothing is taken or shown right after it.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd_ready && !i_pix_valid)
        else $error("command taken or result shown right after reset");

    // A result word always answers an earlier command.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_acc |-> r_pending != 2'd0)
        else $error("result word with no command outstanding");

    // At most one command in work plus one result waiting.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |-> r_pending != 2'd2)
        else $error("command accepted with two words outstanding");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=> i_pix_valid && $stable(i_pix_word))
        else $error("stalled result word dropped or changed");

endmodule

bind framebuffer_alpha_rect_fill_core fbar_checker u_fbar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_pix_valid (o_pix.valid),
    .i_pix_ready (o_pix.ready),
    .i_pix_word  ({o_pix.pix_alpha, o_pix.pix_blue, o_pix.pix_green, o_pix.pix_red})
);

### tb/framebuffer_alpha_rect_fill_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framebuffer_alpha_rect_fill_core_test: self-checking bench of the fill core
// Drives clear, blend fill, read and unused commands through the command
// channel and compares every pixel word against a shadow frame kept here.
// ----------------------------------------------------------------------------
module framebuffer_alpha_rect_fill_core_test;
    import fbar_pkg::*;

    // The frame is kept at its full 256 x 256 size, so a clear or a full
    // screen fill is slow. Those are used sparingly, and most rectangles
    // below are only a few pixels on a side.
    localparam int FRAME_W      = 256;
    localparam int FRAME_H      = 256;
    localparam int CLK_PERIOD   = 2;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 75;
    localparam int MAX_CLEARS   = 3;
    localparam int MAX_IDLE     = 15;
    localparam int DRAIN_CYCLES = 32;
    // The limit is set above the slowest legal run: the zeroing sweep after
    // reset, five clears, one full screen fill, and the rest small work
    // with the longest gaps on both sides.
    localparam int LIMIT_CYCLES = 4_000_000;

    // One command word as it sits on the command channel.
    typedef struct packed {
        t_kind             kind;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [SIZE_W-1:0] rect_width;
        logic [SIZE_W-1:0] rect_height;
        logic [CHAN_W-1:0] src_red;
        logic [CHAN_W-1:0] src_green;
        logic [CHAN_W-1:0] src_blue;
        logic [CHAN_W-1:0] src_alpha;
    } t_draw_cmd;

    // One stored pixel, laid out as the frame word: alpha in the top byte.
    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgba;

    logic clk;
    logic rst_n;

    fbar_cmd_if cmd_bus ();
    fbar_pix_if pix_bus ();

    framebuffer_alpha_rect_fill_core #(
        .FB_WIDTH  (FRAME_W),
        .FB_HEIGHT (FRAME_H)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus),
        .o_pix   (pix_bus)
    );

    // Shadow copy of the frame memory and the pixel words still owed by
    // the core, oldest first.
    t_rgba shadow_frame [FRAME_W*FRAME_H];
    t_rgba pending_pixels [$];
    int    mismatch_count;

    // When set, the matching side runs back to back with no idle cycles.
    bit    sender_burst;
    bit    receiver_burst;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog. A hung handshake ends the run here.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow frame model
    // ------------------------------------------------------------------------

    // Per channel blend: (dst * (255 - a) + src * a) / 255, truncated.
    function automatic logic [CHAN_W-1:0] blend_channel(input int unsigned dst,
                                                        input int unsigned src,
                                                        input int unsigned alpha);
        int unsigned full;
        full = 32'(FULL_SCALE);
        return CHAN_W'((dst * (full - alpha) + src * alpha) / full);
    endfunction

    // Applies one accepted command to the shadow frame and returns the
    // pixel word that the core must answer with. Everything but a read
    // inside the frame answers with all zero.
    function automatic t_rgba apply_draw_cmd(input t_draw_cmd c);
        t_rgba answer;
        t_rgba old;
        int    x_end;
        int    y_end;
        int    x;
        int    y;
        answer = '0;
        case (c.kind)
            KIND_CLEAR: begin
                foreach (shadow_frame[i])
                    shadow_frame[i] = {c.src_alpha, c.src_blue, c.src_green, c.src_red};
            end
            KIND_FILL: begin
                // Clip the far corner at the frame edge; an empty or fully
                // clipped rectangle leaves the loops with nothing to do.
                x_end = int'(c.pos_x) + int'(c.rect_width);
                y_end = int'(c.pos_y) + int'(c.rect_height);
                if (x_end > FRAME_W) x_end = FRAME_W;
                if (y_end > FRAME_H) y_end = FRAME_H;
                for (y = int'(c.pos_y); y < y_end; y++) begin
                    for (x = int'(c.pos_x); x < x_end; x++) begin
                        old = shadow_frame[y*FRAME_W + x];
                        // The stored alpha byte is kept as it was.
                        shadow_frame[y*FRAME_W + x] = {
                            old.alpha,
                            blend_channel(old.blue,  c.src_blue,  c.src_alpha),
                            blend_channel(old.green, c.src_green, c.src_alpha),
                            blend_channel(old.red,   c.src_red,   c.src_alpha)
                        };
                    end
                end
            end
            KIND_READ: begin
                if (int'(c.pos_x) < FRAME_W && int'(c.pos_y) < FRAME_H)
                    answer = shadow_frame[int'(c.pos_y)*FRAME_W + int'(c.pos_x)];
            end
            default: begin
                // The unused kind changes nothing and answers with zero.
            end
        endcase
        return answer;
    endfunction

    function automatic t_draw_cmd make_cmd(input t_kind kind,
                                           input int unsigned x, input int unsigned y,
                                           input int unsigned w, input int unsigned h,
                                           input int unsigned r, input int unsigned g,
                                           input int unsigned b, input int unsigned a);
        t_draw_cmd c;
        c.kind        = kind;
        c.pos_x       = x[POS_W-1:0];
        c.pos_y       = y[POS_W-1:0];
        c.rect_width  = w[SIZE_W-1:0];
        c.rect_height = h[SIZE_W-1:0];
        c.src_red     = r[CHAN_W-1:0];
        c.src_green   = g[CHAN_W-1:0];
        c.src_blue    = b[CHAN_W-1:0];
        c.src_alpha   = a[CHAN_W-1:0];
        return c;
    endfunction

    function automatic int unsigned idle_cycles(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // ------------------------------------------------------------------------
    // Command sender
    // ------------------------------------------------------------------------

    // Called at a falling edge. Valid is only lowered when idle cycles are
    // wanted, so back to back words keep valid high without a glitch. The
    // task returns at the falling edge after its word was taken.
    task automatic send_draw_cmd(input t_draw_cmd c);
        int unsigned idle;
        idle = idle_cycles(sender_burst);
        if (idle > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.kind        <= c.kind;
        cmd_bus.pos_x       <= c.pos_x;
        cmd_bus.pos_y       <= c.pos_y;
        cmd_bus.rect_width  <= c.rect_width;
        cmd_bus.rect_height <= c.rect_height;
        cmd_bus.src_red     <= c.src_red;
        cmd_bus.src_green   <= c.src_green;
        cmd_bus.src_blue    <= c.src_blue;
        cmd_bus.src_alpha   <= c.src_alpha;
        @(posedge clk);
        while (!cmd_bus.ready) @(posedge clk);
        // The word is taken at this edge; the shadow frame moves with it.
        pending_pixels.push_back(apply_draw_cmd(c));
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Pixel word receiver and checker
    // ------------------------------------------------------------------------

    task automatic check_channel(input string name, input logic [CHAN_W-1:0] want,
                                 input logic [CHAN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    initial begin : pixel_checker
        t_rgba       got;
        t_rgba       want;
        int unsigned stall;
        pix_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            // Ready follows the same rule as valid on the command side.
            stall = idle_cycles(receiver_burst);
            if (stall > 0) begin
                pix_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pix_bus.ready <= 1'b1;
            @(posedge clk);
            while (pix_bus.valid !== 1'b1) @(posedge clk);
            got = {pix_bus.pix_alpha, pix_bus.pix_blue, pix_bus.pix_green, pix_bus.pix_red};
            if (pending_pixels.size() == 0) begin
                $display("%0t: pixel word with no command waiting, expected none, actual 0x%08h",
                         $realtime, got);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_channel("pix_red",   want.red,   got.red);
                check_channel("pix_green", want.green, got.green);
                check_channel("pix_blue",  want.blue,  got.blue);
                check_channel("pix_alpha", want.alpha, got.alpha);
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // The zeroing sweep after reset must leave every pixel at zero; the first and last pixels are read.
    task automatic test_reset_state();
        send_draw_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_READ, FRAME_W-1, FRAME_H-1, 0, 0, 0, 0, 0, 0));
    endtask

    // Kind three with corner and colours at their top value and 256 x 256 sides must change nothing.
    task automatic test_unused_kind();
        send_draw_cmd(make_cmd(KIND_NONE, 255, 255, 256, 256, 255, 255, 255, 255));
        send_draw_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // A clear writes all four bytes, alpha included, to every pixel.
    task automatic test_clear();
        send_draw_cmd(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 8'h12, 8'h34, 8'h56, 8'h78));
        send_draw_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_READ, FRAME_W-1, FRAME_H-1, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_READ, 128, 64, 0, 0, 0, 0, 0, 0));
    endtask

    // Alpha zero keeps the frame, alpha full scale replaces the colour but
    // not the stored alpha byte, and a middle alpha rounds down.
    task automatic test_alpha_extremes();
        send_draw_cmd(make_cmd(KIND_FILL, 10, 10, 4, 4, 255, 255, 255, 0));
        send_draw_cmd(make_cmd(KIND_READ, 11, 11, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_FILL, 10, 10, 4, 4, 255, 0, 128, 255));
        send_draw_cmd(make_cmd(KIND_READ, 13, 13, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_READ, 14, 10, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_FILL, 10, 10, 1, 1, 0, 255, 1, 128));
        send_draw_cmd(make_cmd(KIND_READ, 10, 10, 0, 0, 0, 0, 0, 0));
    endtask

    // A zero width or a zero height leaves the frame as it was.
    task automatic test_empty_rect();
        send_draw_cmd(make_cmd(KIND_FILL, 20, 20, 0, 5, 200, 100, 50, 255));
        send_draw_cmd(make_cmd(KIND_FILL, 20, 20, 5, 0, 200, 100, 50, 255));
        send_draw_cmd(make_cmd(KIND_READ, 20, 20, 0, 0, 0, 0, 0, 0));
    endtask

    // A rectangle running past the bottom right corner is cut at the edge.
    task automatic test_edge_clipping();
        send_draw_cmd(make_cmd(KIND_FILL, 250, 250, 256, 256, 8'hC0, 8'h40, 8'h20, 8'h80));
        send_draw_cmd(make_cmd(KIND_READ, 255, 255, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_READ, 250, 250, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_READ, 249, 250, 0, 0, 0, 0, 0, 0));
    endtask

    // Full scale clear, then one blend over the whole frame.
    task automatic test_full_screen();
        send_draw_cmd(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 255, 255, 255, 255));
        send_draw_cmd(make_cmd(KIND_FILL, 0, 0, 256, 256, 0, 0, 0, 1));
        send_draw_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_draw_cmd(make_cmd(KIND_READ, FRAME_W-1, FRAME_H-1, 0, 0, 0, 0, 0, 0));
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------

    // Mostly a fill followed by reads that land inside it, so that blends
    // stack up and get observed. The rest is stray reads, unused commands
    // and a few clears. Both sides switch between bursts and random gaps.
    task automatic test_random_traffic();
        int          sent;
        int          clears;
        int          roll;
        int          reads;
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned span_x;
        int unsigned span_y;
        int unsigned alpha;
        sent   = 0;
        clears = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) sender_burst   = ~sender_burst;
            if ($urandom_range(0, 3) == 0) receiver_burst = ~receiver_burst;
            roll = $urandom_range(0, 99);
            if (roll < 3 && clears < MAX_CLEARS) begin
                send_draw_cmd(make_cmd(KIND_CLEAR, $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 256),
                                       $urandom_range(0, 256), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255)));
                clears++;
                sent++;
            end else if (roll < 10) begin
                send_draw_cmd(make_cmd(KIND_NONE, $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 256),
                                       $urandom_range(0, 256), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255)));
                sent++;
            end else if (roll < 18) begin
                send_draw_cmd(make_cmd(KIND_READ, $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 256),
                                       $urandom_range(0, 256), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255)));
                sent++;
            end else begin
                // Small rectangles mostly; now and then a long thin strip
                // that may reach the frame edge and get clipped.
                if ($urandom_range(0, 99) < 85) begin
                    w = $urandom_range(0, 12);
                    h = $urandom_range(0, 12);
                end else if ($urandom_range(0, 1) == 0) begin
                    w = $urandom_range(0, 256);
                    h = $urandom_range(0, 6);
                end else begin
                    w = $urandom_range(0, 6);
                    h = $urandom_range(0, 256);
                end
                x = ($urandom_range(0, 3) == 0) ? $urandom_range(236, 255)
                                                : $urandom_range(0, 255);
                y = ($urandom_range(0, 3) == 0) ? $urandom_range(236, 255)
                                                : $urandom_range(0, 255);
                roll  = $urandom_range(0, 9);
                alpha = (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom_range(0, 255);
                send_draw_cmd(make_cmd(KIND_FILL, x, y, w, h, $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255),
                                       alpha));
                sent++;
                span_x = (x + w > FRAME_W) ? FRAME_W - x : w;
                span_y = (y + h > FRAME_H) ? FRAME_H - y : h;
                reads  = $urandom_range(1, 3);
                repeat (reads) begin
                    if (span_x > 0 && span_y > 0 && $urandom_range(0, 4) != 0)
                        send_draw_cmd(make_cmd(KIND_READ,
                                               x + $urandom_range(0, span_x - 1),
                                               y + $urandom_range(0, span_y - 1),
                                               $urandom_range(0, 256), $urandom_range(0, 256),
                                               $urandom_range(0, 255), $urandom_range(0, 255),
                                               $urandom_range(0, 255), $urandom_range(0, 255)));
                    else
                        send_draw_cmd(make_cmd(KIND_READ, $urandom_range(0, 255),
                                               $urandom_range(0, 255), 0, 0, 0, 0, 0, 0));
                    sent++;
                end
            end
        end
        sender_burst   = 1'b0;
        receiver_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        rst_n               = 1'b0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.kind        = KIND_CLEAR;
        cmd_bus.pos_x       = '0;
        cmd_bus.pos_y       = '0;
        cmd_bus.rect_width  = '0;
        cmd_bus.rect_height = '0;
        cmd_bus.src_red     = '0;
        cmd_bus.src_green   = '0;
        cmd_bus.src_blue    = '0;
        cmd_bus.src_alpha   = '0;
        mismatch_count      = 0;
        sender_burst        = 1'b0;
        receiver_burst      = 1'b0;
        foreach (shadow_frame[i]) shadow_frame[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The core sweeps its memory to zero before it takes a command;
        // the first send simply waits on ready through that sweep.
        test_reset_state();
        test_unused_kind();
        test_clear();
        test_alpha_extremes();
        test_empty_rect();
        test_edge_clipping();
        test_full_screen();
        test_random_traffic();

        cmd_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        // Let any stray extra word show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
